// ----- hdl/lpp_pkg.sv -----
// Shared constants, types and the quarter-wave sine table of the lidar pixel converter.
package lpp_pkg;

   // Field widths of the stream and register payloads.
   localparam int ANGLE_W    = 9;
   localparam int DIST_W     = 12;
   localparam int SCAN_W     = 8;
   localparam int COORD_W    = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_CENTER_COL  = 2'd0;
   localparam logic [1:0] REG_CENTER_ROW  = 2'd1;
   localparam logic [1:0] REG_IMAGE_LIMIT = 2'd2;

   localparam logic [COORD_W-1:0] CENTER_COL_RESET  = 12'd400;
   localparam logic [COORD_W-1:0] CENTER_ROW_RESET  = 12'd400;
   localparam logic [COORD_W-1:0] IMAGE_LIMIT_RESET = 12'd800;

   // Angle constants in whole degrees.
   localparam logic [ANGLE_W-1:0] QUARTER_TURN_DEG = 9'd90;
   localparam logic [ANGLE_W-1:0] HALF_TURN_DEG    = 9'd180;
   localparam logic [ANGLE_W-1:0] THREE_QUARTER_DEG = 9'd270;
   localparam logic [ANGLE_W-1:0] FULL_TURN_DEG    = 9'd360;

   // Sine fixed point format: SIN_W bits hold 0..2^F, signed values take one more.
   localparam int SINE_FRAC_BITS = 15;
   localparam int SIN_W          = SINE_FRAC_BITS + 1;
   localparam int TABLE_LAST     = 90;
   localparam int PROJ_W         = SINE_FRAC_BITS + 15;

   typedef logic [TABLE_LAST:0][SIN_W-1:0] sin_table_type;

   // Results of one sample, handed from the projection stage to the output queue.
   typedef struct packed {
      logic               mark;
      logic               front_ok;
      logic [COORD_W-1:0] front_col;
      logic [COORD_W-1:0] front_row;
      logic               rear_ok;
      logic [COORD_W-1:0] rear_col;
      logic [COORD_W-1:0] rear_row;
   } bundle_type;

   // Table generation, evaluated only at elaboration.
   localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;
   localparam logic [63:0] DEG_PER_PI = 64'd180;

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type tbl;
      logic [63:0]   q;
      logic [63:0]   r;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [63:0]   k64;
      tbl = '0;
      q   = PI_Q60 / DEG_PER_PI;
      r   = PI_Q60 % DEG_PER_PI;
      for (int k = 0; k <= TABLE_LAST; k++) begin
         k64  = 64'(k);
         x    = q * k64 + (r * k64) / DEG_PER_PI;
         x2   = mul_q60(x, x);
         term = x;
         sum  = x;
         for (int n = 1; n < 20 && term != 64'd0; n++) begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum > ONE_Q60) begin
            sum = ONE_Q60;
         end
         tbl[k] = SIN_W'((sum + (64'd1 << (59 - SINE_FRAC_BITS))) >> (60 - SINE_FRAC_BITS));
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();

endpackage

// ----- hdl/lidar_polar_to_pixel.sv -----
// Top level of the lidar sample to image pixel converter.
//
// Usage: each item on the req_ stream is one lidar sample (angle, front distance,
// rear distance, scan number). Each item on the rsp_ stream is one result: a point
// (tuser low, column and row in tdata) or a scan-end marker (tuser high, tdata zero).
// tlast is high on the final result that a sample causes. A sample may cause zero
// to three results; the first sample after reset only records its scan number.
// The csr_ port holds the origin column, origin row and image limit; write it only
// while the block is idle.
// The results of a sample pass through the input register, the table lookup
// register and the projection into the result register, from which its first
// result can be taken.
// Throughput: one sample per cycle while each sample yields at most one result and
// the receiver takes every result; otherwise the single result port sets the pace
// at one result per cycle while the receiver is ready.
// When the receiver stalls, samples without results still pass through; the result
// register, stage 2 and the input register each hold one sample with results, so up
// to three such samples are taken before req_tready drops. Reset clears the pipeline,
// the pending results and the scan tracking, and loads the register reset values.
module lidar_polar_to_pixel (
   input  logic                             clock,
   input  logic                             reset,
   // Sample stream. tdata: angle_deg[8:0], front_distance[20:9],
   // rear_distance[32:21], scan_id[40:33], zero fill[47:41].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lpp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result stream. tdata: pixel_col[11:0], pixel_row[23:12]. tuser: kind.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lpp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // Register port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lpp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lpp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lpp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = lpp_pkg::ANGLE_W;
   localparam int DW = lpp_pkg::DIST_W;
   localparam int SW = lpp_pkg::SCAN_W;
   localparam int CW = lpp_pkg::COORD_W;
   localparam int TW = lpp_pkg::SIN_W + 1;

   // Configuration registers.
   logic [CW-1:0] center_col_ff, center_col_in;
   logic [CW-1:0] center_row_ff, center_row_in;
   logic [CW-1:0] image_limit_ff, image_limit_in;
   logic          csr_wr;

   // Scan tracking, updated in acceptance order.
   logic          started_ff, started_in;
   logic [SW-1:0] scan_ff, scan_in;

   // Unpacked input fields.
   logic [AW-1:0] req_angle;
   logic [DW-1:0] req_front;
   logic [DW-1:0] req_rear;
   logic [SW-1:0] req_scan;
   logic          req_fire;

   // Stage 1: accepted sample.
   logic          s1_v_ff, s1_v_in;
   logic [AW-1:0] s1_angle_ff, s1_angle_in;
   logic [DW-1:0] s1_front_ff, s1_front_in;
   logic [DW-1:0] s1_rear_ff, s1_rear_in;
   logic          s1_mark_ff, s1_mark_in;
   logic          s1_drop_ff, s1_drop_in;
   logic          s1_move;

   // Stage 2: sample with its sine and cosine.
   logic                 s2_v_ff, s2_v_in;
   logic signed [TW-1:0] s2_sin_ff, s2_sin_in;
   logic signed [TW-1:0] s2_cos_ff, s2_cos_in;
   logic [DW-1:0]        s2_front_ff, s2_front_in;
   logic [DW-1:0]        s2_rear_ff, s2_rear_in;
   logic                 s2_mark_ff, s2_mark_in;
   logic                 s2_drop_ff, s2_drop_in;
   logic                 s2_rdy;
   logic                 s2_go;

   logic signed [TW-1:0] trig_sin;
   logic signed [TW-1:0] trig_cos;
   logic signed [TW-1:0] rear_sin;
   logic signed [TW-1:0] rear_cos;

   logic                front_ok;
   logic [CW-1:0]       front_col;
   logic [CW-1:0]       front_row;
   logic                rear_ok;
   logic [CW-1:0]       rear_col;
   logic [CW-1:0]       rear_row;
   lpp_pkg::bundle_type bundle;
   logic                bundle_any;
   logic                load_en;
   logic                load_ok;

   // ---------------------------------------------------------------------------
   // Register port. Writes complete in the access phase; pready is always high.
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      center_col_in  = center_col_ff;
      center_row_in  = center_row_ff;
      image_limit_in = image_limit_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            lpp_pkg::REG_CENTER_COL:  center_col_in  = csr_pwdata[CW-1:0];
            lpp_pkg::REG_CENTER_ROW:  center_row_in  = csr_pwdata[CW-1:0];
            lpp_pkg::REG_IMAGE_LIMIT: image_limit_in = csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         lpp_pkg::REG_CENTER_COL:  csr_prdata = 32'(center_col_ff);
         lpp_pkg::REG_CENTER_ROW:  csr_prdata = 32'(center_row_ff);
         lpp_pkg::REG_IMAGE_LIMIT: csr_prdata = 32'(image_limit_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff  <= lpp_pkg::CENTER_COL_RESET;
         center_row_ff  <= lpp_pkg::CENTER_ROW_RESET;
         image_limit_ff <= lpp_pkg::IMAGE_LIMIT_RESET;
      end else begin
         center_col_ff  <= center_col_in;
         center_row_ff  <= center_row_in;
         image_limit_ff <= image_limit_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Handshake chain. Each stage moves when the one after it is empty or moving.
   // A sample with no results leaves stage 2 without touching the result register.
   // ---------------------------------------------------------------------------
   assign s2_go      = !bundle_any || load_ok;
   assign s2_rdy     = !s2_v_ff || s2_go;
   assign s1_move    = s1_v_ff && s2_rdy;
   assign req_tready = !s1_v_ff || s2_rdy;
   assign req_fire   = req_tvalid && req_tready;
   assign load_en    = s2_v_ff && bundle_any && load_ok;

   assign req_angle = req_tdata[8:0];
   assign req_front = req_tdata[20:9];
   assign req_rear  = req_tdata[32:21];
   assign req_scan  = req_tdata[40:33];

   // The first sample only records its scan number; later a new scan number
   // puts a scan-end marker ahead of the points of that sample.
   always_comb begin
      started_in  = started_ff;
      scan_in     = scan_ff;
      s1_v_in     = req_fire || (s1_v_ff && !s2_rdy);
      s1_angle_in = s1_angle_ff;
      s1_front_in = s1_front_ff;
      s1_rear_in  = s1_rear_ff;
      s1_mark_in  = s1_mark_ff;
      s1_drop_in  = s1_drop_ff;
      if (req_fire) begin
         started_in  = 1'b1;
         scan_in     = req_scan;
         s1_angle_in = req_angle;
         s1_front_in = req_front;
         s1_rear_in  = req_rear;
         s1_mark_in  = started_ff && (req_scan != scan_ff);
         s1_drop_in  = !started_ff;
      end
   end

   // Stage 1 to stage 2: angle reduction and table lookup.
   lpp_trig u_trig (
      .angle_deg (s1_angle_ff),
      .sin_val   (trig_sin),
      .cos_val   (trig_cos)
   );

   always_comb begin
      s2_v_in     = s1_move || (s2_v_ff && !s2_go);
      s2_sin_in   = s2_sin_ff;
      s2_cos_in   = s2_cos_ff;
      s2_front_in = s2_front_ff;
      s2_rear_in  = s2_rear_ff;
      s2_mark_in  = s2_mark_ff;
      s2_drop_in  = s2_drop_ff;
      if (s1_move) begin
         s2_sin_in   = trig_sin;
         s2_cos_in   = trig_cos;
         s2_front_in = s1_front_ff;
         s2_rear_in  = s1_rear_ff;
         s2_mark_in  = s1_mark_ff;
         s2_drop_in  = s1_drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         scan_ff    <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
      end else begin
         started_ff <= started_in;
         scan_ff    <= scan_in;
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_angle_ff <= s1_angle_in;
      s1_front_ff <= s1_front_in;
      s1_rear_ff  <= s1_rear_in;
      s1_mark_ff  <= s1_mark_in;
      s1_drop_ff  <= s1_drop_in;
      s2_sin_ff   <= s2_sin_in;
      s2_cos_ff   <= s2_cos_in;
      s2_front_ff <= s2_front_in;
      s2_rear_ff  <= s2_rear_in;
      s2_mark_ff  <= s2_mark_in;
      s2_drop_ff  <= s2_drop_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 2 to result register: both projections side by side. The rear beam is
   // half a turn away, so its sine and cosine are the negated front values.
   // ---------------------------------------------------------------------------
   assign rear_sin = -s2_sin_ff;
   assign rear_cos = -s2_cos_ff;

   lpp_project u_front (
      .center_col  (center_col_ff),
      .center_row  (center_row_ff),
      .image_limit (image_limit_ff),
      .distance    (s2_front_ff),
      .cos_val     (s2_cos_ff),
      .sin_val     (s2_sin_ff),
      .point_ok    (front_ok),
      .pixel_col   (front_col),
      .pixel_row   (front_row)
   );

   lpp_project u_rear (
      .center_col  (center_col_ff),
      .center_row  (center_row_ff),
      .image_limit (image_limit_ff),
      .distance    (s2_rear_ff),
      .cos_val     (rear_cos),
      .sin_val     (rear_sin),
      .point_ok    (rear_ok),
      .pixel_col   (rear_col),
      .pixel_row   (rear_row)
   );

   always_comb begin
      bundle.mark      = s2_mark_ff && !s2_drop_ff;
      bundle.front_ok  = front_ok && !s2_drop_ff;
      bundle.front_col = front_col;
      bundle.front_row = front_row;
      bundle.rear_ok   = rear_ok && !s2_drop_ff;
      bundle.rear_col  = rear_col;
      bundle.rear_row  = rear_row;
      bundle_any       = bundle.mark || bundle.front_ok || bundle.rear_ok;
   end

   // Result register and serializer: marker first, then front, then rear point.
   lpp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load       (bundle),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A scan-end marker never carries coordinates.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("scan-end marker with nonzero coordinates");

   // A marker only ever leads its group, so a taken non-final result is followed
   // by a pending point.
   a_marker_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && !rsp_tuser))
      else $error("result group broken or marker not first");

   // The input side only stalls when the input register holds a waiting sample.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_v_ff)
      else $error("input stalled with an empty input register");
`endif

endmodule

// ----- hdl/lpp_trig.sv -----
// Angle reduction and sine/cosine lookup from the quarter-wave table.
module lpp_trig (
   input  logic [lpp_pkg::ANGLE_W-1:0]    angle_deg,
   output logic signed [lpp_pkg::SIN_W:0] sin_val,
   output logic signed [lpp_pkg::SIN_W:0] cos_val
);

   localparam int AW = lpp_pkg::ANGLE_W;

   logic [AW-1:0] angle_red;
   logic [AW:0]   cos_sum;
   logic [AW-1:0] cos_angle;

   // Quadrant folding of a reduced angle onto the table.
   function automatic logic signed [lpp_pkg::SIN_W:0] sin_lookup(input logic [AW-1:0] a);
      logic [6:0] idx;
      logic       negate;
      if (a <= lpp_pkg::QUARTER_TURN_DEG) begin
         idx    = a[6:0];
         negate = 1'b0;
      end else if (a <= lpp_pkg::HALF_TURN_DEG) begin
         idx    = 7'(lpp_pkg::HALF_TURN_DEG - a);
         negate = 1'b0;
      end else if (a <= lpp_pkg::THREE_QUARTER_DEG) begin
         idx    = 7'(a - lpp_pkg::HALF_TURN_DEG);
         negate = 1'b1;
      end else begin
         idx    = 7'(lpp_pkg::FULL_TURN_DEG - a);
         negate = 1'b1;
      end
      if (negate) begin
         return -$signed({1'b0, lpp_pkg::SIN_TABLE[idx]});
      end
      return $signed({1'b0, lpp_pkg::SIN_TABLE[idx]});
   endfunction

   always_comb begin
      angle_red = (angle_deg >= lpp_pkg::FULL_TURN_DEG) ?
                  angle_deg - lpp_pkg::FULL_TURN_DEG : angle_deg;
      cos_sum   = {1'b0, angle_red} + {1'b0, lpp_pkg::QUARTER_TURN_DEG};
      cos_angle = (cos_sum >= {1'b0, lpp_pkg::FULL_TURN_DEG}) ?
                  AW'(cos_sum - {1'b0, lpp_pkg::FULL_TURN_DEG}) : cos_sum[AW-1:0];
   end

   assign sin_val = sin_lookup(angle_red);
   assign cos_val = sin_lookup(cos_angle);

endmodule

// ----- hdl/lpp_project.sv -----
// Projection of one distance onto pixel coordinates with truncation and bounds check.
module lpp_project (
   input  logic [lpp_pkg::COORD_W-1:0]    center_col,
   input  logic [lpp_pkg::COORD_W-1:0]    center_row,
   input  logic [lpp_pkg::COORD_W-1:0]    image_limit,
   input  logic [lpp_pkg::DIST_W-1:0]     distance,
   input  logic signed [lpp_pkg::SIN_W:0] cos_val,
   input  logic signed [lpp_pkg::SIN_W:0] sin_val,
   output logic                           point_ok,
   output logic [lpp_pkg::COORD_W-1:0]    pixel_col,
   output logic [lpp_pkg::COORD_W-1:0]    pixel_row
);

   localparam int F  = lpp_pkg::SINE_FRAC_BITS;
   localparam int VW = lpp_pkg::PROJ_W;
   localparam int QW = VW - F;

   logic signed [lpp_pkg::DIST_W:0] dist_s;
   logic signed [VW-1:0]            prod_c;
   logic signed [VW-1:0]            prod_s;
   logic signed [VW-1:0]            col_base;
   logic signed [VW-1:0]            row_base;
   logic signed [VW-1:0]            col_acc;
   logic signed [VW-1:0]            row_acc;
   logic [VW-1:0]                   col_mag;
   logic [VW-1:0]                   row_mag;
   logic [QW-1:0]                   col_q;
   logic [QW-1:0]                   row_q;
   logic                            col_good;
   logic                            row_good;

   assign dist_s   = $signed({1'b0, distance});
   assign prod_c   = dist_s * cos_val;
   assign prod_s   = dist_s * sin_val;
   assign col_base = $signed({3'b000, center_col, {F{1'b0}}});
   assign row_base = $signed({3'b000, center_row, {F{1'b0}}});
   assign col_acc  = col_base + prod_c;
   assign row_acc  = row_base - prod_s;

   // Truncation toward zero works on the magnitude; a value just below zero lands on zero.
   always_comb begin
      col_mag  = col_acc[VW-1] ? $unsigned(-col_acc) : $unsigned(col_acc);
      row_mag  = row_acc[VW-1] ? $unsigned(-row_acc) : $unsigned(row_acc);
      col_q    = col_mag[VW-1:F];
      row_q    = row_mag[VW-1:F];
      col_good = (!col_acc[VW-1] || col_q == '0) && (col_q <= QW'(image_limit));
      row_good = (!row_acc[VW-1] || row_q == '0) && (row_q <= QW'(image_limit));
   end

   assign point_ok  = col_good && row_good;
   assign pixel_col = col_q[lpp_pkg::COORD_W-1:0];
   assign pixel_row = row_q[lpp_pkg::COORD_W-1:0];

endmodule

// ----- hdl/lpp_out.sv -----
// Result register that holds the results of one sample and sends them one item at a time.
module lpp_out (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load_en,
   input  lpp_pkg::bundle_type              load,
   output logic                             load_ok,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lpp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int CW = lpp_pkg::COORD_W;

   // Pending bits: marker, front point, rear point, sent from the lowest up.
   logic [2:0]    pend_ff;
   logic [2:0]    pend_in;
   logic [CW-1:0] front_col_ff, front_col_in;
   logic [CW-1:0] front_row_ff, front_row_in;
   logic [CW-1:0] rear_col_ff, rear_col_in;
   logic [CW-1:0] rear_row_ff, rear_row_in;
   logic [2:0]    pend_rest;
   logic          rsp_fire;

   assign pend_rest  = pend_ff & (pend_ff - 3'd1);
   assign rsp_tvalid = (pend_ff != 3'b000);
   assign rsp_tlast  = rsp_tvalid && (pend_rest == 3'b000);
   assign rsp_tuser  = pend_ff[0];
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign load_ok    = !rsp_tvalid || (rsp_fire && rsp_tlast);

   always_comb begin
      if (pend_ff[0]) begin
         rsp_tdata = '0;
      end else if (pend_ff[1]) begin
         rsp_tdata = {front_row_ff, front_col_ff};
      end else begin
         rsp_tdata = {rear_row_ff, rear_col_ff};
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      front_col_in = front_col_ff;
      front_row_in = front_row_ff;
      rear_col_in  = rear_col_ff;
      rear_row_in  = rear_row_ff;
      if (load_en) begin
         pend_in      = {load.rear_ok, load.front_ok, load.mark};
         front_col_in = load.front_col;
         front_row_in = load.front_row;
         rear_col_in  = load.rear_col;
         rear_row_in  = load.rear_row;
      end else if (rsp_fire) begin
         pend_in = pend_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'b000;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      front_col_ff <= front_col_in;
      front_row_ff <= front_row_in;
      rear_col_ff  <= rear_col_in;
      rear_row_ff  <= rear_row_in;
   end

endmodule
